### rtl/mcf_pkg.sv
package mcf_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_FEEDBACK = 2'd0;
  localparam logic [1:0] CMD_SET      = 2'd1;
  localparam logic [1:0] CMD_SEND     = 2'd2;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  // map layout
  localparam int MAP_W   = 56;
  localparam int ENTRY_W = 7;

  // feedback identifier bases
  localparam logic [10:0] FB_BASE_T0 = 11'h204;
  localparam logic [10:0] FB_BASE    = 11'h200;

  // command frame identifiers
  localparam logic [10:0] FRAME_ID_0 = 11'h200;
  localparam logic [10:0] FRAME_ID_1 = 11'h1FF;
  localparam logic [10:0] FRAME_ID_2 = 11'h2FF;

  // drive limits per motor type
  localparam logic [15:0] LIM_T0 = 16'd30000;
  localparam logic [15:0] LIM_T1 = 16'd16384;
  localparam logic [15:0] LIM_T2 = 16'd10000;

  // half-turn threshold for wrap detection, counts per turn as a shift
  localparam logic signed [16:0] HALF_TURN  = 17'sd4096;
  localparam int                 TURN_SHIFT = 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_SCAN,
    ST_FB_UPD,
    ST_FB_OUT,
    ST_SET,
    ST_SEND_SCAN,
    ST_SEND_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic cap_in;
    logic scan_clr;
    logic scan_inc;
    logic fb_update;
    logic load_miss;
    logic load_report;
    logic set_drive;
    logic send_acc;
    logic emit_frame;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic fb_match;
    logic any_active;
    logic one_active;
  } dp_stat_t;

  // slot counts as used with the used bit set and an id of 1..8
  function automatic logic entry_used(input logic [ENTRY_W-1:0] e);
    return e[6] && (e[3:0] != 4'd0) && (e[3:0] <= 4'd8);
  endfunction

  function automatic logic [10:0] fb_id(input logic [ENTRY_W-1:0] e);
    logic [10:0] r;
    if (e[5:4] == 2'd0) begin
      r = FB_BASE_T0 + 11'(e[3:0]);
    end else begin
      r = FB_BASE + 11'(e[3:0]);
    end
    return r;
  endfunction

  function automatic logic [15:0] drive_limit(input logic [1:0] t);
    logic [15:0] r;
    unique case (t)
      2'd1:    r = LIM_T1;
      2'd2:    r = LIM_T2;
      default: r = LIM_T0;
    endcase
    return r;
  endfunction

  // frame index 0..2: ids 5..8 move one frame up, type 0 one more
  function automatic logic [1:0] frame_of(input logic [ENTRY_W-1:0] e);
    logic [1:0] f;
    f = (e[3:0] <= 4'd4) ? 2'd0 : 2'd1;
    if (e[5:4] == 2'd0) begin
      f = f + 2'd1;
    end
    return f;
  endfunction

  // 16-bit lane within the frame, lane 0 in bits 63:48
  function automatic logic [1:0] lane_of(input logic [ENTRY_W-1:0] e);
    logic [3:0] m;
    m = e[3:0] - 4'd1;
    return m[1:0];
  endfunction

  function automatic logic [10:0] frame_id(input logic [1:0] f);
    logic [10:0] r;
    unique case (f)
      2'd1:    r = FRAME_ID_1;
      2'd2:    r = FRAME_ID_2;
      default: r = FRAME_ID_0;
    endcase
    return r;
  endfunction

endpackage

### rtl/mcf_ctrl.sv
module mcf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic [1:0]           command_i,
  input  mcf_pkg::dp_stat_t    stat_i,
  output mcf_pkg::ctrl_cmd_t   cmd_o,
  output logic                 busy
);

  mcf_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcf_pkg::ST_IDLE: begin
        if (start) begin
          priority if (command_i == mcf_pkg::CMD_FEEDBACK) begin
            state_d = mcf_pkg::ST_FB_SCAN;
          end else if (command_i == mcf_pkg::CMD_SET) begin
            state_d = mcf_pkg::ST_SET;
          end else if (command_i == mcf_pkg::CMD_SEND) begin
            state_d = mcf_pkg::ST_SEND_SCAN;
          end else begin
            state_d = mcf_pkg::ST_IDLE;
          end
        end
      end
      mcf_pkg::ST_FB_SCAN: begin
        if (stat_i.fb_match) begin
          state_d = mcf_pkg::ST_FB_UPD;
        end else if (stat_i.scan_last) begin
          state_d = mcf_pkg::ST_IDLE;
        end
      end
      mcf_pkg::ST_FB_UPD:    state_d = mcf_pkg::ST_FB_OUT;
      mcf_pkg::ST_FB_OUT:    state_d = mcf_pkg::ST_IDLE;
      mcf_pkg::ST_SET:       state_d = mcf_pkg::ST_IDLE;
      mcf_pkg::ST_SEND_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = mcf_pkg::ST_SEND_OUT;
        end
      end
      mcf_pkg::ST_SEND_OUT: begin
        if (!stat_i.any_active || stat_i.one_active) begin
          state_d = mcf_pkg::ST_IDLE;
        end
      end
      default: state_d = mcf_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      mcf_pkg::ST_IDLE: begin
        busy           = 1'b0;
        cmd_o.cap_in   = start;
        cmd_o.scan_clr = start;
      end
      mcf_pkg::ST_FB_SCAN: begin
        cmd_o.load_miss = !stat_i.fb_match && stat_i.scan_last;
        cmd_o.scan_inc  = !stat_i.fb_match && !stat_i.scan_last;
      end
      mcf_pkg::ST_FB_UPD:  cmd_o.fb_update   = 1'b1;
      mcf_pkg::ST_FB_OUT:  cmd_o.load_report = 1'b1;
      mcf_pkg::ST_SET:     cmd_o.set_drive   = 1'b1;
      mcf_pkg::ST_SEND_SCAN: begin
        cmd_o.send_acc = 1'b1;
        cmd_o.scan_inc = !stat_i.scan_last;
      end
      mcf_pkg::ST_SEND_OUT: cmd_o.emit_frame = stat_i.any_active;
      default: busy = 1'b1;
    endcase
  end

endmodule

### rtl/mcf_datapath.sv
module mcf_datapath #(
  parameter int SLOTS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mcf_pkg::MAP_W-1:0]  cfg_wdata_i,
  input  logic [10:0]                frame_id_i,
  input  logic [63:0]                frame_data_i,
  input  logic [2:0]                 slot_i,
  input  logic signed [15:0]         drive_value_i,
  input  mcf_pkg::ctrl_cmd_t         cmd_i,
  output mcf_pkg::dp_stat_t          stat_o,
  output logic                       valid_o,
  output logic                       kind_o,
  output logic                       hit_o,
  output logic [2:0]                 hit_slot_o,
  output logic [15:0]                encoder_o,
  output logic signed [45:0]         position_o,
  output logic signed [15:0]         speed_rpm_o,
  output logic signed [15:0]         motor_current_o,
  output logic [7:0]                 temperature_o,
  output logic [31:0]                report_count_o,
  output logic [10:0]                out_id_o,
  output logic [63:0]                out_data_o,
  output logic                       last_o
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [mcf_pkg::MAP_W-1:0] map_q;

  // per-slot state
  logic [15:0] last_enc_q [SLOTS];
  logic [31:0] turn_q     [SLOTS];
  logic        seen_q     [SLOTS];
  logic [31:0] fcnt_q     [SLOTS];
  logic [15:0] drive_q    [SLOTS];

  // captured input word
  logic [10:0]        fid_q;
  logic [63:0]        fdata_q;
  logic [2:0]         slot_q;
  logic signed [15:0] dval_q;

  logic [SlotW-1:0] cnt_q;

  // frame assembly
  logic [63:0] data_q [3];
  logic [2:0]  active_q;

  logic [mcf_pkg::ENTRY_W-1:0] cur_entry, set_entry;
  logic                        cur_used, set_ok;
  logic [SlotW-1:0]            set_idx;
  logic [15:0]                 ecd;
  logic signed [16:0]          diff;
  logic [31:0]                 turn_next;
  logic signed [16:0]          lim, dv_ext;
  logic [15:0]                 clamp_val;
  logic [1:0]                  f_acc, lane_acc, f_emit;
  logic signed [45:0]          pos_calc;

  // slot under the scan pointer
  assign cur_entry = map_q[mcf_pkg::ENTRY_W*int'(cnt_q) +: mcf_pkg::ENTRY_W];
  assign cur_used  = mcf_pkg::entry_used(cur_entry);

  assign stat_o.scan_last  = (cnt_q == SlotW'(SLOTS - 1));
  assign stat_o.fb_match   = cur_used && (fid_q == mcf_pkg::fb_id(cur_entry));
  assign stat_o.any_active = |active_q;
  assign stat_o.one_active = (active_q == 3'b001) || (active_q == 3'b010) ||
                             (active_q == 3'b100);

  // wrap tracking for the matched slot
  assign ecd  = fdata_q[63:48];
  assign diff = $signed({1'b0, ecd}) - $signed({1'b0, last_enc_q[cnt_q]});
  always_comb begin
    turn_next = turn_q[cnt_q];
    if (seen_q[cnt_q]) begin
      if (diff > mcf_pkg::HALF_TURN) begin
        turn_next = turn_q[cnt_q] - 32'd1;
      end else if (diff < -mcf_pkg::HALF_TURN) begin
        turn_next = turn_q[cnt_q] + 32'd1;
      end
    end
  end

  // multi-turn position from stored turn count
  assign pos_calc = $signed({turn_q[cnt_q][31], turn_q[cnt_q],
                             {mcf_pkg::TURN_SHIFT{1'b0}}}) +
                    $signed({30'd0, last_enc_q[cnt_q]});

  // set command: slot check and clamp
  assign set_entry = map_q[mcf_pkg::ENTRY_W*int'(slot_q) +: mcf_pkg::ENTRY_W];
  assign set_ok    = ({1'b0, slot_q} < 4'(SLOTS)) && mcf_pkg::entry_used(set_entry);
  assign set_idx   = slot_q[SlotW-1:0];
  assign lim       = $signed({1'b0, mcf_pkg::drive_limit(set_entry[5:4])});
  assign dv_ext    = 17'(dval_q);
  always_comb begin
    if (dv_ext > lim) begin
      clamp_val = lim[15:0];
    end else if (dv_ext < -lim) begin
      clamp_val = 16'(-lim);
    end else begin
      clamp_val = dv_ext[15:0];
    end
  end

  // frame placement of the scanned slot, lowest pending frame to emit
  assign f_acc    = mcf_pkg::frame_of(cur_entry);
  assign lane_acc = mcf_pkg::lane_of(cur_entry);
  always_comb begin
    priority if (active_q[0]) begin
      f_emit = 2'd0;
    end else if (active_q[1]) begin
      f_emit = 2'd1;
    end else begin
      f_emit = 2'd2;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else if (cfg_we_i) begin
      map_q <= cfg_wdata_i;
    end
  end

  // slot table, cleared per slot when its map entry changes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        last_enc_q[k] <= '0;
        turn_q[k]     <= '0;
        seen_q[k]     <= 1'b0;
        fcnt_q[k]     <= '0;
        drive_q[k]    <= '0;
      end
    end else begin
      for (int k = 0; k < SLOTS; k++) begin
        if (cfg_we_i && (cfg_wdata_i[mcf_pkg::ENTRY_W*k +: mcf_pkg::ENTRY_W] !=
                         map_q[mcf_pkg::ENTRY_W*k +: mcf_pkg::ENTRY_W])) begin
          last_enc_q[k] <= '0;
          turn_q[k]     <= '0;
          seen_q[k]     <= 1'b0;
          fcnt_q[k]     <= '0;
          drive_q[k]    <= '0;
        end else begin
          if (cmd_i.fb_update && (cnt_q == SlotW'(k))) begin
            last_enc_q[k] <= ecd;
            turn_q[k]     <= turn_next;
            seen_q[k]     <= 1'b1;
            fcnt_q[k]     <= fcnt_q[k] + 32'd1;
          end
          if (cmd_i.set_drive && set_ok && (set_idx == SlotW'(k))) begin
            drive_q[k] <= clamp_val;
          end
        end
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      fid_q   <= frame_id_i;
      fdata_q <= frame_data_i;
      slot_q  <= slot_i;
      dval_q  <= drive_value_i;
    end
  end

  // slot scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.scan_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.scan_inc) begin
      cnt_q <= cnt_q + SlotW'(1);
    end
  end

  // pending command frames
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.scan_clr) begin
      active_q <= '0;
    end else if (cmd_i.send_acc && cur_used) begin
      active_q[f_acc] <= 1'b1;
    end else if (cmd_i.emit_frame) begin
      active_q[f_emit] <= 1'b0;
    end
  end

  // frame payloads, later slots overwrite a shared lane
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      for (int f = 0; f < 3; f++) begin
        data_q[f] <= '0;
      end
    end else if (cmd_i.send_acc && cur_used) begin
      data_q[f_acc][16*(3-int'(lane_acc)) +: 16] <= drive_q[cnt_q];
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.load_miss || cmd_i.load_report || cmd_i.emit_frame;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_miss || cmd_i.load_report || cmd_i.emit_frame) begin
      kind_o          <= cmd_i.emit_frame ? mcf_pkg::KIND_FRAME : mcf_pkg::KIND_REPORT;
      hit_o           <= cmd_i.load_report;
      hit_slot_o      <= '0;
      encoder_o       <= '0;
      position_o      <= '0;
      speed_rpm_o     <= '0;
      motor_current_o <= '0;
      temperature_o   <= '0;
      report_count_o  <= '0;
      out_id_o        <= '0;
      out_data_o      <= '0;
      last_o          <= 1'b1;
      if (cmd_i.load_report) begin
        hit_slot_o      <= 3'(cnt_q);
        encoder_o       <= last_enc_q[cnt_q];
        position_o      <= pos_calc;
        speed_rpm_o     <= fdata_q[47:32];
        motor_current_o <= fdata_q[31:16];
        temperature_o   <= fdata_q[15:8];
        report_count_o  <= fcnt_q[cnt_q];
      end
      if (cmd_i.emit_frame) begin
        out_id_o   <= mcf_pkg::frame_id(f_emit);
        out_data_o <= data_q[f_emit];
        last_o     <= stat_o.one_active;
      end
    end
  end

endmodule

### rtl/motor_can_feedback_and_command.sv
// Motor slot table with feedback decoding and command frame packing. A word is taken on
// start while busy is low and results leave as single-cycle strobes on valid_o, which
// the receiver cannot hold off; last_o marks the final result of a word. Timing is set
// by the slot walk, which visits one slot per cycle: a set command occupies a single
// state; a feedback frame matching slot k walks slots 0 to k, then updates that slot
// and loads its report; a frame matching no slot walks every slot and reports a miss;
// a send walks every slot to pack frames, then strobes the pending frames back to
// back in identifier order 0x200, 0x1FF, 0x2FF. cfg_we_i may be pulsed only while idle;
// a slot whose map entry changes has its tracking state and drive value cleared.
module motor_can_feedback_and_command #(
  parameter int SLOTS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mcf_pkg::MAP_W-1:0] cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command_i,
  input  logic [10:0]               frame_id_i,
  input  logic [63:0]               frame_data_i,
  input  logic [2:0]                slot_i,
  input  logic signed [15:0]        drive_value_i,
  output logic                      valid_o,
  output logic                      kind_o,
  output logic                      hit_o,
  output logic [2:0]                hit_slot_o,
  output logic [15:0]               encoder_o,
  output logic signed [45:0]        position_o,
  output logic signed [15:0]        speed_rpm_o,
  output logic signed [15:0]        motor_current_o,
  output logic [7:0]                temperature_o,
  output logic [31:0]               report_count_o,
  output logic [10:0]               out_id_o,
  output logic [63:0]               out_data_o,
  output logic                      last_o
);

  mcf_pkg::ctrl_cmd_t ctrl_cmd;
  mcf_pkg::dp_stat_t  dp_stat;

  // sequencer
  mcf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (ctrl_cmd),
    .busy      (busy)
  );

  // slot table and result registers
  mcf_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .frame_id_i      (frame_id_i),
    .frame_data_i    (frame_data_i),
    .slot_i          (slot_i),
    .drive_value_i   (drive_value_i),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .valid_o         (valid_o),
    .kind_o          (kind_o),
    .hit_o           (hit_o),
    .hit_slot_o      (hit_slot_o),
    .encoder_o       (encoder_o),
    .position_o      (position_o),
    .speed_rpm_o     (speed_rpm_o),
    .motor_current_o (motor_current_o),
    .temperature_o   (temperature_o),
    .report_count_o  (report_count_o),
    .out_id_o        (out_id_o),
    .out_data_o      (out_data_o),
    .last_o          (last_o)
  );

  // a feedback word yields exactly one report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (kind_o == mcf_pkg::KIND_REPORT) |-> last_o)
    else $error("feedback report without last");

  // the last result of a word is never directly followed by another result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result strobe right after last word");

  // a known command occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && ((command_i == mcf_pkg::CMD_FEEDBACK) ||
                       (command_i == mcf_pkg::CMD_SET) ||
                       (command_i == mcf_pkg::CMD_SEND)) |=> busy)
    else $error("accepted command did not raise busy");

  // command frames carry a valid identifier and no hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (kind_o == mcf_pkg::KIND_FRAME) |->
      !hit_o && ((out_id_o == mcf_pkg::FRAME_ID_0) ||
                 (out_id_o == mcf_pkg::FRAME_ID_1) ||
                 (out_id_o == mcf_pkg::FRAME_ID_2)))
    else $error("malformed command frame");

endmodule
